// ===== src/bts_pkg.sv =====
// Shared types and constants for the binary trie string set.
`default_nettype none
package bts_pkg;

	localparam int NodeCountDefault = 4096;
	localparam int BitsPerSymbol    = 8;
	localparam int BitIdxW          = $clog2(BitsPerSymbol);

	localparam logic OpInsert = 1'b0;
	localparam logic OpFind   = 1'b1;

	localparam logic StatusOk       = 1'b0;
	localparam logic StatusOverflow = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] byte_value;
		logic       byte_present;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_LINK,
		ST_ALLOC,
		ST_END,
		ST_TAIL,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic latch;     // capture the input item
		logic rd_cur;    // read node at cursor
		logic follow;    // step to existing child, read it
		logic lose;      // find miss
		logic overflow;  // pool exhausted
		logic link_wr;   // write parent with new link
		logic alloc;     // clear new node, step into it
		logic mark_wr;   // set word end at cursor
		logic finish;    // load result, clear string state
	} cmd_t;

	typedef struct packed {
		logic lost;
		logic insert;
		logic last;
		logic link_nz;
		logic pool_ok;
		logic last_bit;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== src/bts_ctrl.sv =====
// Sequencer for trie walks, node allocation and result transfer.
`default_nettype none
module bts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_present,
	input  wire bts_pkg::stat_t stat,
	output bts_pkg::cmd_t      cmd,
	output logic               req_stall
);

	bts_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			bts_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = (req_present && !stat.lost) ? bts_pkg::ST_WALK_RD
						: bts_pkg::ST_END;
				end
			end
			bts_pkg::ST_WALK_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = bts_pkg::ST_WALK_EV;
			end
			bts_pkg::ST_WALK_EV: begin
				priority if (stat.link_nz) begin
					cmd.follow = 1'b1;
					state_d    = stat.last_bit ? bts_pkg::ST_END : bts_pkg::ST_WALK_EV;
				end else if (!stat.insert) begin
					cmd.lose = 1'b1;
					state_d  = bts_pkg::ST_END;
				end else if (stat.pool_ok) begin
					state_d = bts_pkg::ST_LINK;
				end else begin
					cmd.overflow = 1'b1;
					state_d      = bts_pkg::ST_END;
				end
			end
			bts_pkg::ST_LINK: begin
				cmd.link_wr = 1'b1;
				state_d     = bts_pkg::ST_ALLOC;
			end
			bts_pkg::ST_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = stat.last_bit ? bts_pkg::ST_END : bts_pkg::ST_WALK_EV;
			end
			bts_pkg::ST_END: begin
				priority if (!stat.last) begin
					state_d = bts_pkg::ST_IDLE;
				end else if (stat.lost) begin
					state_d = bts_pkg::ST_RESULT;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = bts_pkg::ST_TAIL;
				end
			end
			bts_pkg::ST_TAIL: begin
				cmd.mark_wr = stat.insert;
				state_d     = bts_pkg::ST_RESULT;
			end
			bts_pkg::ST_RESULT: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = bts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/bts_dpath.sv =====
// Node memory, walk registers, pool counter and result register.
`default_nettype none
module bts_dpath #(
	parameter int NODE_COUNT = bts_pkg::NodeCountDefault
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bts_pkg::in_item_t req,
	input  wire bts_pkg::cmd_t     cmd,
	input  wire logic             rsp_stall,
	output bts_pkg::stat_t        stat,
	output logic                  rsp_valid,
	output bts_pkg::out_item_t    rsp
);

	localparam int AW = $clog2(NODE_COUNT);
	localparam int NW = $clog2(NODE_COUNT + 1);
	localparam int DW = 1 + 2 * AW;
	localparam int EndBit = 2 * AW;

	logic [DW-1:0] mem [NODE_COUNT];
	logic [DW-1:0] rd_q;
	logic          root_valid_q;

	logic [AW-1:0]               cursor_q;
	logic [NW-1:0]               next_free_q;
	logic                        lost_q;
	logic                        ovf_q;
	logic                        opcode_q;
	logic                        last_q;
	logic [7:0]                  byte_q;
	logic [bts_pkg::BitIdxW-1:0] bit_q;
	logic                        out_valid_q;
	bts_pkg::out_item_t          out_q;

	logic [DW-1:0] node;
	logic          bit_val;
	logic [AW-1:0] link;
	logic [AW-1:0] new_idx;
	logic [DW-1:0] wdata;
	logic [AW-1:0] addr;
	logic          mem_we;
	logic          mem_re;
	logic          out_free;
	logic          insert;

	assign node    = (cursor_q == '0 && !root_valid_q) ? '0 : rd_q;
	assign bit_val = byte_q[bit_q];
	assign link    = bit_val ? node[2*AW-1:AW] : node[AW-1:0];
	assign new_idx = next_free_q[AW-1:0];
	assign insert  = (opcode_q == bts_pkg::OpInsert);

	assign mem_re = cmd.rd_cur | cmd.follow;
	assign mem_we = cmd.link_wr | cmd.alloc | cmd.mark_wr;

	always_comb begin
		addr  = cursor_q;
		wdata = node;
		priority if (cmd.follow) begin
			addr = link;
		end else if (cmd.alloc) begin
			addr  = new_idx;
			wdata = '0;
		end else if (cmd.link_wr) begin
			if (bit_val) begin
				wdata[2*AW-1:AW] = new_idx;
			end else begin
				wdata[AW-1:0] = new_idx;
			end
		end else if (cmd.mark_wr) begin
			wdata[EndBit] = 1'b1;
		end else begin
			addr = cursor_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= mem[addr];
		end else if (cmd.alloc) begin
			rd_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid_q <= 1'b0;
		end else if (mem_we && addr == '0) begin
			root_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			opcode_q <= req.opcode;
			last_q   <= req.last;
			byte_q   <= req.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			next_free_q <= NW'(1);
			lost_q      <= 1'b0;
			ovf_q       <= 1'b0;
			bit_q       <= '0;
		end else begin
			if (cmd.latch) begin
				bit_q <= '0;
			end
			if (cmd.follow) begin
				cursor_q <= link;
				bit_q    <= bit_q + 1'b1;
			end
			if (cmd.alloc) begin
				cursor_q    <= new_idx;
				next_free_q <= next_free_q + 1'b1;
				bit_q       <= bit_q + 1'b1;
			end
			if (cmd.lose) begin
				lost_q <= 1'b1;
			end
			if (cmd.overflow) begin
				lost_q <= 1'b1;
				ovf_q  <= 1'b1;
			end
			if (cmd.finish) begin
				cursor_q <= '0;
				lost_q   <= 1'b0;
				ovf_q    <= 1'b0;
			end
		end
	end

	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.found  <= insert ? !lost_q : (!lost_q && node[EndBit]);
			out_q.status <= ovf_q ? bts_pkg::StatusOverflow : bts_pkg::StatusOk;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		stat          = '0;
		stat.lost     = lost_q;
		stat.insert   = insert;
		stat.last     = last_q;
		stat.link_nz  = (link != '0);
		stat.pool_ok  = (next_free_q < NW'(NODE_COUNT));
		stat.last_bit = (bit_q == bts_pkg::BitIdxW'(bts_pkg::BitsPerSymbol - 1));
		stat.out_free = out_free;
	end

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= NW'(NODE_COUNT))
		else $error("pool counter past node count");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> next_free_q < NW'(NODE_COUNT))
		else $error("allocation from an empty pool");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we))
		else $error("node memory read and write in one cycle");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (cursor_q == '0 && !lost_q && !ovf_q && out_valid_q))
		else $error("string state not cleared after result");

	a_step_nonroot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.follow || cmd.alloc) |=> cursor_q != '0)
		else $error("walk stepped back to root");

endmodule
`default_nettype wire

// ===== src/binary_trie_string_set_core.sv =====
// Binary trie string set: top level joining sequencer and datapath.
//
// Strings arrive on the req channel one byte per transfer, with a last mark
// and an opcode (insert or find). Only the transfer with last set yields a
// result on the rsp channel: found, and status flagging pool exhaustion.
// Each byte is walked LSB first, one trie level per bit, through a single
// port node memory with registered read data.
// Per input transfer the sequencer accepts the item, reads the current node,
// then walks each bit: a step along an existing node, or for a bit that
// creates a node a decide, a link write and a clear-and-step; then an end
// step. A find miss or overflow ends the walk early, and a transfer without
// a byte goes from accept straight to the end step. A last transfer adds a
// mark write slot and a result load, only the load if the walk stopped;
// rsp_valid rises the cycle after the result load.
// Reset clears the root node (by a valid flag), the pool counter and the
// walk state; no memory sweep is needed. The node memory is not cleared.
// A result sits in the rsp register while rsp_stall is high; the next item
// is still accepted and walked, and only its result waits for the register.
`default_nettype none
module binary_trie_string_set_core #(
	parameter int NODE_COUNT = bts_pkg::NodeCountDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire bts_pkg::in_item_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output bts_pkg::out_item_t     rsp
);

	bts_pkg::cmd_t  cmd;
	bts_pkg::stat_t stat;

	bts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_present (req.byte_present),
		.stat        (stat),
		.cmd         (cmd),
		.req_stall   (req_stall)
	);

	bts_dpath #(
		.NODE_COUNT (NODE_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== tb/trie_membership_checker.sv =====
// Checker for the binary trie string set: predicts each answer and compares it.
`default_nettype none
module trie_membership_checker #(
	parameter int NODE_COUNT = bts_pkg::NodeCountDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_stall,
	input  wire bts_pkg::in_item_t  req,
	input  wire logic               rsp_valid,
	input  wire logic               rsp_stall,
	input  wire bts_pkg::out_item_t rsp,
	output int unsigned             mismatches,
	output int unsigned             pending,
	output int unsigned             answers,
	output int unsigned             hits,
	output int unsigned             overflows
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NodeW = $clog2(NODE_COUNT);

	logic [NodeW-1:0]   link_one  [NODE_COUNT];
	logic [NodeW-1:0]   link_zero [NODE_COUNT];
	logic               word_mark [NODE_COUNT];
	logic [NodeW:0]     pool_next;
	logic [NodeW-1:0]   at_node;
	logic               walk_stopped;
	logic               pool_ran_out;
	bts_pkg::out_item_t expected_answers [$];

	function automatic void trie_clear();
		int n;
		for (n = 0; n < NODE_COUNT; n++) begin
			link_one[n]  = '0;
			link_zero[n] = '0;
			word_mark[n] = 1'b0;
		end
		pool_next    = (NodeW+1)'(1);
		at_node      = '0;
		walk_stopped = 1'b0;
		pool_ran_out = 1'b0;
	endfunction

	// One byte, LSB first; a set bit follows the link_one child.
	function automatic void trie_descend(input logic [7:0] b, input logic grow);
		int i;
		logic [NodeW-1:0] child;
		i = 0;
		while (i < bts_pkg::BitsPerSymbol && !walk_stopped) begin
			child = b[i] ? link_one[at_node] : link_zero[at_node];
			if (child == '0) begin
				if (!grow) begin
					walk_stopped = 1'b1;
				end else if (pool_next >= (NodeW+1)'(NODE_COUNT)) begin
					pool_ran_out = 1'b1;
					walk_stopped = 1'b1;
				end else begin
					child = pool_next[NodeW-1:0];
					pool_next = pool_next + 1'b1;
					link_one[child]  = '0;
					link_zero[child] = '0;
					word_mark[child] = 1'b0;
					if (b[i])
						link_one[at_node] = child;
					else
						link_zero[at_node] = child;
				end
			end
			if (!walk_stopped)
				at_node = child;
			i++;
		end
	endfunction

	function automatic void trie_apply(input bts_pkg::in_item_t it);
		bts_pkg::out_item_t ans;
		if (it.byte_present)
			trie_descend(it.byte_value, it.opcode == bts_pkg::OpInsert);
		if (it.last) begin
			if (it.opcode == bts_pkg::OpInsert) begin
				ans.found = !walk_stopped;
				if (!walk_stopped)
					word_mark[at_node] = 1'b1;
			end else begin
				ans.found = !walk_stopped && word_mark[at_node];
			end
			ans.status = pool_ran_out ? bts_pkg::StatusOverflow : bts_pkg::StatusOk;
			expected_answers.push_back(ans);
			at_node      = '0;
			walk_stopped = 1'b0;
			pool_ran_out = 1'b0;
		end
	endfunction

	// Inputs change only at the rising edge, so the falling edge sees what the next edge takes.
	always @(negedge clk) begin
		bts_pkg::out_item_t want;
		if (!arst_n) begin
			trie_clear();
			expected_answers.delete();
			mismatches = 0;
			answers    = 0;
			hits       = 0;
			overflows  = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				answers++;
				if (rsp.found === 1'b1)
					hits++;
				if (rsp.status === bts_pkg::StatusOverflow)
					overflows++;
				if (expected_answers.size() == 0) begin
					mismatches++;
					$display("%0t: answer expected none got found=%b status=%b", $time,
						rsp.found, rsp.status);
				end else begin
					want = expected_answers.pop_front();
					if (rsp.found !== want.found) begin
						mismatches++;
						$display("%0t: found expected %b got %b", $time, want.found, rsp.found);
					end
					if (rsp.status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %b got %b", $time, want.status,
							rsp.status);
					end
				end
			end
			if (req_valid && !req_stall)
				trie_apply(req);
		end
		pending = expected_answers.size();
	end

endmodule
`default_nettype wire

// ===== tb/binary_trie_string_set_core_tb.sv =====
// Testbench top for the binary trie string set: stimulus, flow control and verdict.
`default_nettype none
module binary_trie_string_set_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 2000000;
	localparam int HoldCycles = 600;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	bts_pkg::in_item_t  req       = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	bts_pkg::out_item_t rsp;

	int unsigned mismatches, pending, answers, hits, overflows;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned items_sent    = 0;
	int unsigned cycles        = 0;
	logic        hold_ask      = 1'b0;

	logic [7:0] word [$];
	logic [7:0] kept_bytes [256][12];
	int         kept_len [256];
	int         kept_total = 0;

	binary_trie_string_set_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	trie_membership_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.mismatches(mismatches),
		.pending(pending),
		.answers(answers),
		.hits(hits),
		.overflows(overflows)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d answers outstanding", cycles, pending);
		$display("FAIL binary_trie_string_set_core");
		$finish;
	end

	// Response side: random stalls, or a long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (hold_ask) begin
				hold_ask = 1'b0;
				hold_left = HoldCycles;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic logic [7:0] random_byte();
		int unsigned r;
		logic [7:0] b;
		r = $urandom_range(99);
		b = 8'($urandom_range(255));
		if (r < 50) begin
			b = 8'($urandom_range(3));
			b = 8'h61 + b;
		end else if (r < 62) begin
			b = $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return b;
	endfunction

	task automatic offer(input logic op, input logic [7:0] b, input logic present,
		input logic last);
		logic held;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req.opcode       <= op;
		req.byte_value   <= b;
		req.byte_present <= present;
		req.last         <= last;
		req_valid        <= 1'b1;
		held = 1'b1;
		while (held) begin
			@(negedge clk);
			held = req_stall;
			@(posedge clk);
		end
		if (present || last)
			items_sent++;
	endtask

	// Sends the bytes in word; empty_tail ends it with an item that carries no byte.
	task automatic send_word(input logic op, input logic mixed, input logic empty_tail);
		int i;
		logic byte_op;
		for (i = 0; i < word.size(); i++) begin
			if ($urandom_range(29) == 0)
				offer(op, random_byte(), 1'b0, 1'b0);
			byte_op = op;
			if (mixed)
				byte_op = 1'($urandom_range(1));
			offer(byte_op, word[i], 1'b1, (i == word.size() - 1) && !empty_tail);
		end
		if (empty_tail || word.size() == 0)
			offer(op, random_byte(), 1'b0, 1'b1);
	endtask

	task automatic run_phase(input int unsigned upto);
		int unsigned pick;
		int n, k, slot;
		while (items_sent < upto) begin
			pick = $urandom_range(99);
			word.delete();
			if (pick < 40 || kept_total == 0) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
				slot = kept_total % 256;
				for (k = 0; k < n; k++) begin
					word.push_back(random_byte());
					kept_bytes[slot][k] = word[k];
				end
				kept_len[slot] = n;
				kept_total++;
				send_word(bts_pkg::OpInsert, 1'b0, 1'b0);
			end else if (pick < 75) begin
				n = (kept_total < 256) ? kept_total : 256;
				slot = $urandom_range(n - 1);
				for (k = 0; k < kept_len[slot]; k++)
					word.push_back(kept_bytes[slot][k]);
				if ($urandom_range(4) == 0) begin
					case ($urandom_range(2))
						0: if (word.size() > 1) word.delete(word.size() - 1);
						1: word.push_back(random_byte());
						default: begin
							k = $urandom_range(word.size() - 1);
							word[k] = word[k] ^ (8'h01 << $urandom_range(7));
						end
					endcase
				end
				send_word(($urandom_range(4) == 0) ? bts_pkg::OpInsert : bts_pkg::OpFind,
					1'b0, 1'b0);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) word.push_back(random_byte());
				send_word(bts_pkg::OpFind, 1'b0, 1'b0);
			end else if (pick < 90) begin
				send_word(1'($urandom_range(1)), 1'b0, 1'b1);
			end else begin
				repeat ($urandom_range(1, 5)) word.push_back(random_byte());
				send_word(1'($urandom_range(1)), 1'b1, $urandom_range(3) == 0);
			end
		end
	endtask

	initial begin
		int tries;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty strings against the root
		offer(bts_pkg::OpFind,   8'h00, 1'b0, 1'b1);
		offer(bts_pkg::OpInsert, 8'hFF, 1'b0, 1'b1);
		offer(bts_pkg::OpFind,   8'h00, 1'b0, 1'b1);
		// byte extremes, hits and a miss
		offer(bts_pkg::OpInsert, 8'h00, 1'b1, 1'b1);
		offer(bts_pkg::OpInsert, 8'hFF, 1'b1, 1'b1);
		offer(bts_pkg::OpFind,   8'h00, 1'b1, 1'b1);
		offer(bts_pkg::OpFind,   8'hFF, 1'b1, 1'b1);
		offer(bts_pkg::OpFind,   8'h01, 1'b1, 1'b1);
		// prefix exists but is not a word end
		offer(bts_pkg::OpInsert, 8'hFF, 1'b1, 1'b0);
		offer(bts_pkg::OpInsert, 8'h00, 1'b1, 1'b0);
		offer(bts_pkg::OpInsert, 8'hA5, 1'b1, 1'b1);
		offer(bts_pkg::OpFind,   8'hFF, 1'b1, 1'b0);
		offer(bts_pkg::OpFind,   8'h00, 1'b1, 1'b1);
		offer(bts_pkg::OpFind,   8'hFF, 1'b1, 1'b0);
		offer(bts_pkg::OpFind,   8'h00, 1'b1, 1'b0);
		offer(bts_pkg::OpFind,   8'hA5, 1'b1, 1'b1);
		// mixed opcodes within one string
		offer(bts_pkg::OpFind,   8'h00, 1'b1, 1'b0);
		offer(bts_pkg::OpInsert, 8'h5A, 1'b1, 1'b1);
		// find stops at the first byte, second byte not walked
		offer(bts_pkg::OpFind,   8'h77, 1'b1, 1'b0);
		offer(bts_pkg::OpFind,   8'h00, 1'b1, 1'b1);
		// empty items inside and at the end of a string
		offer(bts_pkg::OpInsert, 8'h11, 1'b1, 1'b0);
		offer(bts_pkg::OpInsert, 8'h00, 1'b0, 1'b0);
		offer(bts_pkg::OpInsert, 8'h22, 1'b1, 1'b1);
		offer(bts_pkg::OpFind,   8'h11, 1'b1, 1'b0);
		offer(bts_pkg::OpFind,   8'h00, 1'b0, 1'b1);

		send_idle_pct = 32;
		stall_pct     = 55;
		run_phase(items_sent + 250);
		hold_ask = 1'b1;
		run_phase(items_sent + 250);
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);

		send_idle_pct = 55;
		stall_pct     = 32;
		run_phase(items_sent + 480);
		// long random inserts until the node pool runs dry
		tries = 0;
		while (overflows == 0 && tries < 150) begin
			word.delete();
			repeat (8) word.push_back(8'($urandom_range(255)));
			send_word(bts_pkg::OpInsert, 1'b0, 1'b0);
			tries++;
		end
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);

		send_idle_pct = 0;
		stall_pct     = 0;
		run_phase(items_sent + 400);
		req_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d bytes and end marks; checked %0d answers,", items_sent, answers);
		$display("%0d with found set, %0d overflowed; mixed idling and one long hold-off.",
			hits, overflows);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS binary_trie_string_set_core");
		end else begin
			$display("%0d mismatches, %0d answers never arrived", mismatches, pending);
			$display("FAIL binary_trie_string_set_core");
		end
		$finish;
	end

endmodule
`default_nettype wire
